[hdl/iehid_pkg.sv]
// Package with the types, codes and lookup functions of the event to HID report translator.
`default_nettype none

package iehid_pkg;

    // Default number of keyboard slots kept in state.
    localparam int KEY_SLOTS_DEF = 6;
    // Number of slots that appear in the keyboard report.
    localparam int KB_SHOWN_MAX  = 6;

    // Event kinds.
    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_ABS   = 2'd1,
        KIND_REL   = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    // Report selectors.
    typedef enum logic [1:0] {
        RPT_GAMEPAD  = 2'd0,
        RPT_MOUSE    = 2'd1,
        RPT_KEYBOARD = 2'd2,
        RPT_NONE     = 2'd3
    } t_report_sel;

    // Report lengths in bytes.
    localparam logic [3:0] GP_BYTES = 4'd7;
    localparam logic [3:0] MS_BYTES = 4'd6;
    localparam logic [3:0] KB_BYTES = 4'd8;

    // Linux input event codes that have a fixed meaning here.
    localparam logic [15:0] CODE_DPAD_BASE = 16'h0220;
    localparam logic [15:0] CODE_BTN_MODE  = 16'h013c;
    localparam logic [15:0] CODE_BTN_TR2   = 16'h0139;
    localparam logic [15:0] CODE_BTN_TL2   = 16'h0138;
    localparam logic [15:0] CODE_THUMBL    = 16'h013d;
    localparam logic [15:0] CODE_KEY_D     = 16'h0020;
    localparam logic [15:0] CODE_AXIS_X    = 16'h0000;
    localparam logic [15:0] CODE_AXIS_Y    = 16'h0001;
    localparam logic [15:0] CODE_AXIS_Z    = 16'h0002;

    // Input event payload.
    typedef struct packed {
        t_kind              kind;
        logic        [15:0] code;
        logic signed [31:0] value;
        logic               queue_drained;
    } t_event;

    // Report payload.
    typedef struct packed {
        t_report_sel report_sel;
        logic [63:0] payload;
        logic [3:0]  payload_bytes;
        logic        last;
    } t_report;

    // Configuration write payload.
    typedef struct packed {
        logic notify_on;
    } t_cfg;

    // Report images and their last sent copies.
    typedef struct packed {
        logic [3:0]  dpad_bits;
        logic [55:0] gp_report;
        logic [55:0] gp_sent;
        logic [47:0] ms_report;
        logic [47:0] ms_sent;
        logic [7:0]  key_mods;
        logic [63:0] kb_sent;
    } t_img_state;

    // Reports produced by one event.
    typedef struct packed {
        logic [2:0]  mask;     // bit 0 gamepad, bit 1 mouse, bit 2 keyboard
        logic [55:0] gp_img;
        logic [47:0] ms_img;
        logic [63:0] kb_img;
    } t_emit;

    // Keyboard usage lookup result.
    typedef struct packed {
        logic       hit;
        logic [7:0] usage;
    } t_kb_map;

    // Eight-way hat from the d-pad bits (up, down, left, right); 8 is centered.
    function automatic logic [7:0] hat_of(input logic [3:0] dpad);
        logic [7:0] hat;
        unique case (dpad)
            4'd1:    hat = 8'd0;
            4'd2:    hat = 8'd4;
            4'd4:    hat = 8'd6;
            4'd5:    hat = 8'd7;
            4'd6:    hat = 8'd5;
            4'd8:    hat = 8'd2;
            4'd9:    hat = 8'd1;
            4'd10:   hat = 8'd3;
            default: hat = 8'd8;
        endcase
        return hat;
    endfunction

    // Keyboard usage for the keys that land in the slot list.
    function automatic t_kb_map kb_lookup(input logic [15:0] code);
        t_kb_map m;
        m.hit = 1'b1;
        unique case (code)
            16'h000b: m.usage = 8'h52;
            16'h0002: m.usage = 8'h51;
            16'h0003: m.usage = 8'h50;
            16'h0004: m.usage = 8'h4f;
            16'h0133: m.usage = 8'h17;
            16'h0130: m.usage = 8'h09;
            16'h0134: m.usage = 8'h15;
            16'h0131: m.usage = 8'h19;
            16'h013a: m.usage = 8'h2b;
            16'h013b: m.usage = 8'h29;
            16'h001e: m.usage = 8'h10;
            16'h0030: m.usage = 8'h11;
            16'h0136: m.usage = 8'h14;
            16'h0137: m.usage = 8'h08;
            16'h002e: m.usage = 8'h2c;
            default: begin
                m.hit   = 1'b0;
                m.usage = 8'h00;
            end
        endcase
        return m;
    endfunction

    // Saturate a signed 32-bit value to 16 bits.
    function automatic logic [15:0] sat16(input logic signed [31:0] v);
        logic [15:0] r;
        if (v[31:15] == {17{v[31]}}) begin
            r = v[15:0];
        end else begin
            r = v[31] ? 16'h8000 : 16'h7fff;
        end
        return r;
    endfunction

    // Saturate a signed 32-bit value to 8 bits.
    function automatic logic [7:0] sat8(input logic signed [31:0] v);
        logic [7:0] r;
        if (v[31:7] == {25{v[31]}}) begin
            r = v[7:0];
        end else begin
            r = v[31] ? 8'h80 : 8'h7f;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/iehid_chan_if.sv]
// Valid/ready channel interface carrying one payload type.
`default_nettype none

interface iehid_chan_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/input_event_to_hid_reports.sv]
// Top level of the input event to HID report translator.
// Each event (key, absolute or relative axis) is taken into an input register and, once
// the report register can take new reports, applied to the gamepad, mouse and keyboard
// report images in one pass; every report that then differs from its last sent copy is
// loaded into a three-entry report register and sent on o_rpt in the order gamepad,
// mouse, keyboard, with last set on the final one. A new event is accepted every cycle
// as long as each event yields at most one report and o_rpt takes each report when it
// is presented; an event that yields several reports holds the single report channel
// until its last report is sent. Reports are only produced while notify_on is set and
// the event carries queue_drained. The configuration channel is always ready and is
// meant to be written while the block is idle.
`default_nettype none

module input_event_to_hid_reports #(
    parameter int KEY_SLOTS = iehid_pkg::KEY_SLOTS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    iehid_chan_if.sink       i_evt,
    iehid_chan_if.sink       i_cfg,
    iehid_chan_if.source     o_rpt
);
    import iehid_pkg::*;

    // Input register.
    logic                    r_in_valid;
    t_event                  r_evt;
    logic                    r_notify;

    // Report state.
    t_img_state              r_st;
    logic [KEY_SLOTS-1:0][7:0] r_slots;
    t_img_state              n_st;
    logic [KEY_SLOTS-1:0][7:0] n_slots;
    t_emit                   w_emit;

    // Pending reports of the current event.
    logic [2:0]              r_pend;
    logic [55:0]             r_gp_img;
    logic [47:0]             r_ms_img;
    logic [63:0]             r_kb_img;

    logic                    w_out_xfer;
    logic                    w_can_load;
    logic                    w_process;

    iehid_next #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_next (
        .i_evt       (r_evt),
        .i_notify_on (r_notify),
        .i_st        (r_st),
        .i_slots     (r_slots),
        .o_st        (n_st),
        .o_slots     (n_slots),
        .o_emit      (w_emit)
    );

    // Handshake control: the report register can take new reports when it empties.
    assign w_out_xfer = o_rpt.valid && o_rpt.ready;
    assign w_can_load = (r_pend == 3'b000) || (w_out_xfer && $onehot(r_pend));
    assign w_process  = r_in_valid && w_can_load;
    assign i_evt.ready = !r_in_valid || w_process;
    assign i_cfg.ready = 1'b1;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_notify <= 1'b0;
        end else if (i_cfg.valid) begin
            r_notify <= i_cfg.data.notify_on;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_evt <= i_evt.data;
        end
    end

    // Report images, updated when an event is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= '0;
            r_slots <= '0;
        end else if (w_process) begin
            r_st    <= n_st;
            r_slots <= n_slots;
        end
    end

    // Pending report mask: load on process, drop the oldest on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'b000;
        end else if (w_process) begin
            r_pend <= w_emit.mask;
        end else if (w_out_xfer) begin
            r_pend <= r_pend & (r_pend - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_gp_img <= w_emit.gp_img;
            r_ms_img <= w_emit.ms_img;
            r_kb_img <= w_emit.kb_img;
        end
    end

    // Output selection: the oldest pending report goes first.
    always_comb begin
        o_rpt.valid = |r_pend;
        o_rpt.data.last = $onehot(r_pend);
        priority if (r_pend[0]) begin
            o_rpt.data.report_sel    = RPT_GAMEPAD;
            o_rpt.data.payload       = {8'd0, r_gp_img};
            o_rpt.data.payload_bytes = GP_BYTES;
        end else if (r_pend[1]) begin
            o_rpt.data.report_sel    = RPT_MOUSE;
            o_rpt.data.payload       = {16'd0, r_ms_img};
            o_rpt.data.payload_bytes = MS_BYTES;
        end else begin
            o_rpt.data.report_sel    = RPT_KEYBOARD;
            o_rpt.data.payload       = r_kb_img;
            o_rpt.data.payload_bytes = KB_BYTES;
        end
    end

    // Checks.
    a_mouse_sent_no_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.ms_sent[47:8] == 40'd0)
        else $error("mouse sent copy holds motion");

    a_emit_shows_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_process && (w_emit.mask != 3'b000) |=> o_rpt.valid)
        else $error("emitted report not presented");

    a_sent_only_on_process: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_process |=> $stable(r_st.gp_sent) && $stable(r_st.kb_sent))
        else $error("sent copy changed without an event");

    a_keyboard_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rpt.valid && !o_rpt.data.last |-> o_rpt.data.report_sel != RPT_KEYBOARD)
        else $error("keyboard report not last");

endmodule

`default_nettype wire

[hdl/iehid_next.sv]
// Next-state and report emission logic for one event.
`default_nettype none

module iehid_next #(
    parameter int KEY_SLOTS = iehid_pkg::KEY_SLOTS_DEF
) (
    input  wire iehid_pkg::t_event          i_evt,
    input  wire                             i_notify_on,
    input  wire iehid_pkg::t_img_state      i_st,
    input  wire [KEY_SLOTS-1:0][7:0]        i_slots,
    output iehid_pkg::t_img_state           o_st,
    output logic [KEY_SLOTS-1:0][7:0]       o_slots,
    output iehid_pkg::t_emit                o_emit
);
    import iehid_pkg::*;

    localparam int SHOWN = (KEY_SLOTS < KB_SHOWN_MAX) ? KEY_SLOTS : KB_SHOWN_MAX;

    t_img_state w_upd;
    logic       w_pressed;
    t_kb_map    w_map;
    logic [7:0] w_match;
    logic [7:0] w_fill;
    logic       w_found;
    logic [3:0] w_dpad;
    logic [63:0] w_kb_img;
    logic       w_en;

    assign w_pressed = |i_evt.value;
    assign w_map     = kb_lookup(i_evt.code);
    assign w_match   = w_pressed ? 8'h00 : w_map.usage;
    assign w_fill    = w_pressed ? w_map.usage : 8'h00;

    // Apply the event to the report images.
    always_comb begin
        w_upd   = i_st;
        o_slots = i_slots;
        w_dpad  = i_st.dpad_bits;
        w_found = 1'b0;
        unique case (i_evt.kind)
            KIND_KEY: begin
                // D-pad keys feed the hat.
                if (i_evt.code[15:2] == CODE_DPAD_BASE[15:2]) begin
                    w_dpad[i_evt.code[1:0]] = w_pressed;
                    w_upd.dpad_bits         = w_dpad;
                    w_upd.gp_report[7:0]    = hat_of(w_dpad);
                end
                if (i_evt.code == CODE_BTN_MODE) begin
                    w_upd.gp_report[16] = w_pressed;
                end
                if (i_evt.code == CODE_BTN_TR2) begin
                    w_upd.ms_report[0] = w_pressed;
                end
                if (i_evt.code == CODE_BTN_TL2) begin
                    w_upd.ms_report[1] = w_pressed;
                end
                // Modifiers first; other mapped keys take or free a slot.
                if (i_evt.code == CODE_THUMBL) begin
                    w_upd.key_mods[1] = w_pressed;
                end else if (i_evt.code == CODE_KEY_D) begin
                    w_upd.key_mods[0] = w_pressed;
                end else if (w_map.hit) begin
                    for (int s = 0; s < KEY_SLOTS; s++) begin
                        if (!w_found && i_slots[s] == w_match) begin
                            o_slots[s] = w_fill;
                            w_found    = 1'b1;
                        end
                    end
                end
            end
            KIND_ABS: begin
                if (i_evt.code == CODE_AXIS_X) begin
                    w_upd.gp_report[31:24] = (|i_evt.value[31:8]) ? 8'hff : i_evt.value[7:0];
                end else if (i_evt.code == CODE_AXIS_Y) begin
                    w_upd.gp_report[39:32] = (|i_evt.value[31:8]) ? 8'hff : i_evt.value[7:0];
                end
            end
            KIND_REL: begin
                if (i_evt.code == CODE_AXIS_X) begin
                    w_upd.ms_report[23:8] = sat16(i_evt.value);
                end else if (i_evt.code == CODE_AXIS_Y) begin
                    w_upd.ms_report[39:24] = sat16(i_evt.value);
                end else if (i_evt.code == CODE_AXIS_Z) begin
                    w_upd.ms_report[47:40] = sat8(i_evt.value);
                end
            end
            default: begin
            end
        endcase
    end

    // Keyboard image: modifiers, a reserved byte, then the shown slots.
    always_comb begin
        w_kb_img       = 64'd0;
        w_kb_img[7:0]  = w_upd.key_mods;
        for (int i = 0; i < SHOWN; i++) begin
            w_kb_img[16 + 8*i +: 8] = o_slots[i];
        end
    end

    assign w_en = i_notify_on && i_evt.queue_drained;

    // Compare against the sent copies and pick the reports to send.
    always_comb begin
        o_st          = w_upd;
        o_emit.gp_img = w_upd.gp_report;
        o_emit.ms_img = w_upd.ms_report;
        o_emit.kb_img = w_kb_img;
        o_emit.mask[0] = w_en && (w_upd.gp_report != i_st.gp_sent);
        o_emit.mask[1] = w_en && (w_upd.ms_report != i_st.ms_sent);
        o_emit.mask[2] = w_en && (w_kb_img != i_st.kb_sent);
        if (o_emit.mask[0]) begin
            o_st.gp_sent = w_upd.gp_report;
        end
        // Mouse motion is relative, so it is cleared once it has been sent.
        if (o_emit.mask[1]) begin
            o_st.ms_report = {40'd0, w_upd.ms_report[7:0]};
            o_st.ms_sent   = {40'd0, w_upd.ms_report[7:0]};
        end
        if (o_emit.mask[2]) begin
            o_st.kb_sent = w_kb_img;
        end
    end

endmodule

`default_nettype wire
